// File: design/elc_pkg.sv
// ----------------------------------------------------------------------------
// elc_pkg: shared types and constants of the extent LRU cache
// Opcodes, channel payloads and entry layout.
// ----------------------------------------------------------------------------
package elc_pkg;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_ADD    = 2'd1,
		OP_INVAL  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [31:0] file_cluster;
		logic [31:0]        disk_cluster;
		logic [30:0]        run_length;
		logic [31:0]        generation_tag;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] offset;
		logic [30:0]        near_file_cluster;
		logic [31:0]        near_disk_cluster;
		logic [30:0]        entry_file_cluster;
		logic [31:0]        entry_disk_cluster;
		logic [30:0]        entry_run_length;
		logic [31:0]        current_generation;
	} rsp_t;

	typedef struct packed {
		logic [30:0] start_file;
		logic [31:0] start_disk;
		logic [30:0] run_len;
	} entry_t;

	localparam logic [31:0] GEN_RESET = 32'd1;

endpackage

// File: design/elc_req_if.sv
// ----------------------------------------------------------------------------
// elc_req_if: request channel
// Valid/ready channel carrying one cache operation per beat.
// ----------------------------------------------------------------------------
interface elc_req_if;
	logic          valid;
	logic          ready;
	elc_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/elc_rsp_if.sv
// ----------------------------------------------------------------------------
// elc_rsp_if: response channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface elc_rsp_if;
	logic          valid;
	logic          ready;
	elc_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/extent_lru_cache_core.sv
// ----------------------------------------------------------------------------
// extent_lru_cache_core: LRU cache of file-to-disk cluster extents
// Entries in a synchronous RAM, recency order in a rank table, scanned
// one entry per cycle by a sequencer.
// ----------------------------------------------------------------------------
// channel  dir  payload
// req      in   op, file_cluster, disk_cluster, run_length, generation_tag
// rsp      out  hit, offset, near/entry clusters, current_generation
//
// Lookup and add scan the valid entries in recency order, so their result
// waits on the number of valid entries, at most ENTRIES; this is set by the
// single read port of the entry RAM. Invalidate skips the scan. Requests are
// taken only in the idle state, one at a time. No clearing pass after reset;
// rank table and count reset at once. A new request is taken while a result
// waits in the output register; the next result waits until that beat leaves.
module extent_lru_cache_core #(
	parameter int ENTRIES = 16
) (
	input logic      clk,
	input logic      arst_n,
	elc_req_if.sink  req,
	elc_rsp_if.source rsp
);
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_FIN, ST_SEND} state_t;

	state_t              state_q;
	elc_pkg::req_t       cur_q;
	logic [AW-1:0]       rank_q [ENTRIES];
	logic [CW-1:0]       count_q;
	logic [31:0]         gen_q;
	logic [CW-1:0]       r_q;
	logic [AW-1:0]       ridx_q;
	logic                rvld_q;
	logic                found_q;
	logic [AW-1:0]       hidx_q;
	elc_pkg::entry_t     hent_q;
	logic [31:0]         off_q;
	logic [30:0]         best_q;
	logic                done_q;
	elc_pkg::rsp_t       out_q;
	logic                ovld_q;

	logic                we;
	logic [AW-1:0]       waddr;
	elc_pkg::entry_t     wdata;
	logic [AW-1:0]       raddr;
	elc_pkg::entry_t     rdata;
	logic [AW-1:0]       rank_idx;

	elc_entry_ram #(.ENTRIES(ENTRIES), .AW(AW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// entry index holding rank r_q
	always_comb begin
		rank_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (rank_q[i] == r_q[AW-1:0] && i < int'(count_q)) begin
				rank_idx = AW'(i);
			end
		end
	end
	assign raddr = rank_idx;

	logic        take;
	logic [32:0] endp;
	logic        lk_take;
	logic        ad_take;
	logic        tag_ok;
	assign tag_ok = cur_q.generation_tag == '0 || cur_q.generation_tag == gen_q;
	assign endp   = {2'b0, rdata.start_file} + {2'b0, rdata.run_len};
	assign lk_take = !cur_q.file_cluster[31] && rvld_q && !done_q &&
		rdata.start_file <= cur_q.file_cluster[30:0] ? 1'b1 : 1'b0;
	assign take = lk_take && rdata.start_file <= cur_q.file_cluster[30:0] &&
		rdata.start_file > best_q;
	assign ad_take = rvld_q && !done_q && rdata.start_file == cur_q.file_cluster[30:0];

	logic ready_int;
	assign ready_int = state_q == ST_IDLE;
	assign req.ready = ready_int;
	assign rsp.valid = ovld_q;
	assign rsp.data  = out_q;

	// finishing work
	logic            fin_upd;
	logic [AW-1:0]   fin_idx;
	logic            add_ok;
	logic            full;
	logic            new_slot;
	assign add_ok = !cur_q.file_cluster[31] && tag_ok;
	assign full   = count_q == CW'(ENTRIES);
	assign new_slot = elc_pkg::op_t'(cur_q.op) == elc_pkg::OP_ADD && !found_q && !full;

	always_comb begin
		we = 1'b0; waddr = hidx_q; wdata = hent_q;
		fin_upd = 1'b0; fin_idx = hidx_q;
		if (state_q == ST_FIN) begin
			if (elc_pkg::op_t'(cur_q.op) == elc_pkg::OP_LOOKUP) begin
				fin_upd = found_q;
			end else if (elc_pkg::op_t'(cur_q.op) == elc_pkg::OP_ADD && add_ok) begin
				fin_upd = 1'b1;
				we = 1'b1;
				if (found_q) begin
					wdata = hent_q;
					if (cur_q.run_length > hent_q.run_len) begin
						wdata.run_len = cur_q.run_length;
					end
				end else begin
					fin_idx = full ? hidx_q : count_q[AW-1:0];
					waddr = fin_idx;
					wdata.start_file = cur_q.file_cluster[30:0];
					wdata.start_disk = cur_q.disk_cluster;
					wdata.run_len = cur_q.run_length;
				end
			end
		end
	end

	elc_pkg::rsp_t res_d;
	always_comb begin
		res_d = '0;
		res_d.offset = '1;
		res_d.current_generation = gen_q;
		if (elc_pkg::op_t'(cur_q.op) == elc_pkg::OP_LOOKUP && found_q) begin
			res_d.hit = 1'b1;
			res_d.offset = off_q;
			res_d.near_file_cluster = hent_q.start_file + off_q[30:0];
			res_d.near_disk_cluster = hent_q.start_disk + off_q;
			res_d.entry_file_cluster = hent_q.start_file;
			res_d.entry_disk_cluster = hent_q.start_disk;
			res_d.entry_run_length = hent_q.run_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			gen_q   <= elc_pkg::GEN_RESET;
			ovld_q  <= 1'b0;
			rvld_q  <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
		end else begin
			if (ovld_q && rsp.ready && state_q != ST_SEND) ovld_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req.valid && ready_int) begin
						cur_q   <= req.data;
						r_q     <= '0;
						rvld_q  <= 1'b0;
						found_q <= 1'b0;
						done_q  <= 1'b0;
						best_q  <= '0;
						off_q   <= '1;
						state_q <= (req.data.op == elc_pkg::OP_LOOKUP ||
							req.data.op == elc_pkg::OP_ADD) ? ST_SCAN : ST_FIN;
					end
				end
				ST_SCAN: begin
					if (elc_pkg::op_t'(cur_q.op) == elc_pkg::OP_LOOKUP && take) begin
						found_q <= 1'b1;
						hidx_q  <= ridx_q;
						hent_q  <= rdata;
						best_q  <= rdata.start_file;
						if (endp < {2'b0, cur_q.file_cluster[30:0]}) begin
							off_q <= {1'b0, rdata.run_len};
						end else begin
							off_q  <= {1'b0, cur_q.file_cluster[30:0] - rdata.start_file};
							done_q <= 1'b1;
						end
					end
					if (elc_pkg::op_t'(cur_q.op) == elc_pkg::OP_ADD && ad_take) begin
						found_q <= 1'b1;
						done_q  <= 1'b1;
						hidx_q  <= ridx_q;
						hent_q  <= rdata;
					end
					if (elc_pkg::op_t'(cur_q.op) == elc_pkg::OP_ADD && !found_q &&
						!ad_take && rvld_q && full) begin
						hidx_q <= ridx_q;
					end
					ridx_q <= rank_idx;
					if (r_q < count_q) begin
						rvld_q <= 1'b1;
						r_q    <= r_q + 1'b1;
					end else begin
						rvld_q  <= 1'b0;
						state_q <= rvld_q ? ST_SCAN : ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_upd) begin
						for (int i = 0; i < ENTRIES; i++) begin
							if (AW'(i) == fin_idx) begin
								rank_q[i] <= '0;
							end else if (i < int'(count_q) &&
								(new_slot || rank_q[i] < rank_q[fin_idx])) begin
								rank_q[i] <= rank_q[i] + 1'b1;
							end
						end
						if (new_slot) begin
							count_q <= count_q + 1'b1;
						end
					end
					if (elc_pkg::op_t'(cur_q.op) == elc_pkg::OP_INVAL) begin
						count_q <= '0;
						for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
						gen_q <= (gen_q == '1) ? 32'd1 : gen_q + 32'd1;
					end
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (!ovld_q || rsp.ready) begin
						ovld_q  <= 1'b1;
						out_q   <= res_d;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: design/elc_entry_ram.sv
// ----------------------------------------------------------------------------
// elc_entry_ram: extent entry store
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module elc_entry_ram #(
	parameter int ENTRIES = 16,
	parameter int AW      = 4
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  elc_pkg::entry_t       wdata,
	input  logic [AW-1:0]         raddr,
	output elc_pkg::entry_t       rdata
);
	elc_pkg::entry_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: design/elc_checker.sv
// ----------------------------------------------------------------------------
// elc_checker: port-level checks of the extent LRU cache
// Handshake and result sanity, bound to the top level.
// ----------------------------------------------------------------------------
module elc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input elc_pkg::rsp_t rsp_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result dropped while stalled");
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.hit |-> rsp_data.offset == -32'sd1)
		else $error("miss without offset -1");
	a_gen: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.current_generation != 32'd0)
		else $error("generation zero");
	a_near: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.hit |-> rsp_data.offset >= 0)
		else $error("negative offset on hit");
endmodule

bind extent_lru_cache_core elc_checker u_elc_checker (
	.clk(clk), .arst_n(arst_n), .rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the extent LRU cache core
// Queue-fed driver and clocked monitor with random gaps on both channels.
// A behavioral copy of the cache predicts every response, and the monitor
// compares each response beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int N_ENT = 16;

	logic clk;
	logic arst_n;
	elc_req_if req_ch ();
	elc_rsp_if rsp_ch ();

	extent_lru_cache_core #(.ENTRIES(N_ENT)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	// cache shadow
	logic [30:0] sh_file [N_ENT];
	logic [31:0] sh_disk [N_ENT];
	logic [30:0] sh_len [N_ENT];
	int unsigned sh_rank [N_ENT];
	int unsigned sh_count;
	logic [31:0] sh_gen;

	elc_pkg::req_t pending_reqs[$];
	elc_pkg::rsp_t expected_rsps[$];
	int errors;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int rank_to_idx(int unsigned r);
		for (int i = 0; i < N_ENT; i++)
			if (i < sh_count && sh_rank[i] == r)
				return i;
		return -1;
	endfunction

	function automatic void promote_entry(int idx);
		int unsigned old;
		old = sh_rank[idx];
		for (int i = 0; i < N_ENT; i++)
			if (i < sh_count && sh_rank[i] < old)
				sh_rank[i]++;
		sh_rank[idx] = 0;
	endfunction

	function automatic elc_pkg::rsp_t cache_apply(elc_pkg::req_t q);
		elc_pkg::rsp_t res;
		int hit_idx;
		int found;
		int idx;
		longint fc;
		longint best;
		longint off;
		longint s;
		hit_idx = -1;
		best = 0;
		off = -1;
		fc = longint'(q.file_cluster);
		res = '0;
		res.offset = -1;
		case (elc_pkg::op_t'(q.op))
			elc_pkg::OP_LOOKUP: begin
				for (int unsigned r = 0; r < sh_count; r++) begin
					idx = rank_to_idx(r);
					if (idx >= 0) begin
						s = longint'({1'b0, sh_file[idx]});
						if (s <= fc && best < s) begin
							hit_idx = idx;
							best = s;
							if (s + longint'({1'b0, sh_len[idx]}) < fc) begin
								off = longint'({1'b0, sh_len[idx]});
							end else begin
								off = fc - s;
								break;
							end
						end
					end
				end
				if (hit_idx >= 0) begin
					promote_entry(hit_idx);
					res.hit = 1'b1;
					res.offset = off[31:0];
					res.near_file_cluster = sh_file[hit_idx] + off[30:0];
					res.near_disk_cluster = sh_disk[hit_idx] + off[31:0];
					res.entry_file_cluster = sh_file[hit_idx];
					res.entry_disk_cluster = sh_disk[hit_idx];
					res.entry_run_length = sh_len[hit_idx];
				end
			end
			elc_pkg::OP_ADD: begin
				if (fc >= 0 && (q.generation_tag == 0 || q.generation_tag == sh_gen)) begin
					found = -1;
					for (int unsigned r = 0; r < sh_count; r++) begin
						idx = rank_to_idx(r);
						if (idx >= 0 && sh_file[idx] == q.file_cluster[30:0]) begin
							found = idx;
							break;
						end
					end
					if (found >= 0) begin
						if (q.run_length > sh_len[found])
							sh_len[found] = q.run_length;
						promote_entry(found);
					end else begin
						if (sh_count < N_ENT) begin
							idx = sh_count;
							sh_rank[idx] = sh_count;
							sh_count++;
						end else begin
							idx = rank_to_idx(sh_count - 1);
							if (idx < 0)
								idx = 0;
						end
						sh_file[idx] = q.file_cluster[30:0];
						sh_disk[idx] = q.disk_cluster;
						sh_len[idx] = q.run_length;
						promote_entry(idx);
					end
				end
			end
			elc_pkg::OP_INVAL: begin
				sh_count = 0;
				for (int i = 0; i < N_ENT; i++)
					sh_rank[i] = 0;
				sh_gen++;
				if (sh_gen == 0)
					sh_gen++;
			end
			default: ;
		endcase
		res.current_generation = sh_gen;
		return res;
	endfunction

	function automatic elc_pkg::req_t mk_req(elc_pkg::op_t o, logic [31:0] f,
			logic [31:0] d, logic [30:0] l, logic [31:0] g);
		elc_pkg::req_t q;
		q.op = o;
		q.file_cluster = f;
		q.disk_cluster = d;
		q.run_length = l;
		q.generation_tag = g;
		return q;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 9) < 4)
			return 0;
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// driver
	int drv_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data <= '0;
			drv_gap = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				void'(pending_reqs.pop_front());
				drv_gap = gap_len();
			end
			if (drv_gap > 0) begin
				drv_gap--;
				req_ch.valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				req_ch.valid <= 1'b1;
				req_ch.data <= pending_reqs[0];
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// predict on acceptance, at the same edge as the handshake
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			expected_rsps.push_back(cache_apply(req_ch.data));
	end

	// monitor
	int stall;
	always @(posedge clk or negedge arst_n) begin
		elc_pkg::rsp_t want;
		elc_pkg::rsp_t got;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_ch.data;
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected response %h", $time, got);
					errors++;
				end else begin
					want = expected_rsps.pop_front();
					if (got.hit !== want.hit || got.offset !== want.offset ||
							got.near_file_cluster !== want.near_file_cluster ||
							got.near_disk_cluster !== want.near_disk_cluster ||
							got.entry_file_cluster !== want.entry_file_cluster ||
							got.entry_disk_cluster !== want.entry_disk_cluster ||
							got.entry_run_length !== want.entry_run_length ||
							got.current_generation !== want.current_generation) begin
						$display("%0t: expected hit=%0d off=%0d nf=%h nd=%h ef=%h ed=%h el=%h gen=%h",
							$time, want.hit, want.offset, want.near_file_cluster,
							want.near_disk_cluster, want.entry_file_cluster,
							want.entry_disk_cluster, want.entry_run_length,
							want.current_generation);
						$display("%0t: actual   hit=%0d off=%0d nf=%h nd=%h ef=%h ed=%h el=%h gen=%h",
							$time, got.hit, got.offset, got.near_file_cluster,
							got.near_disk_cluster, got.entry_file_cluster,
							got.entry_disk_cluster, got.entry_run_length,
							got.current_generation);
						errors++;
					end
				end
			end
			if (stall > 0) begin
				stall--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				stall = gap_len();
			end
		end
	end

	// stimulus
	logic [31:0] bases [8];
	initial begin
		logic [31:0] f;
		logic [31:0] g;
		int k;
		errors = 0;
		sh_count = 0;
		sh_gen = elc_pkg::GEN_RESET;
		for (int i = 0; i < N_ENT; i++)
			sh_rank[i] = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed
		pending_reqs.push_back(mk_req(elc_pkg::OP_LOOKUP, 32'd5, 0, 0, 0));
		pending_reqs.push_back(mk_req(elc_pkg::OP_ADD, 32'hFFFF_FFFF, 32'd9, 31'd4, 0));
		pending_reqs.push_back(mk_req(elc_pkg::OP_ADD, 32'h8000_0000, 32'd9, 31'd4, 0));
		pending_reqs.push_back(mk_req(elc_pkg::OP_ADD, 32'd0, 32'd100, 31'd10, 0));
		pending_reqs.push_back(mk_req(elc_pkg::OP_LOOKUP, 32'd3, 0, 0, 0));
		pending_reqs.push_back(mk_req(elc_pkg::OP_ADD, 32'd10, 32'hFFFF_FFF0, 31'd5,
			32'd1));
		pending_reqs.push_back(mk_req(elc_pkg::OP_LOOKUP, 32'd14, 0, 0, 0));
		pending_reqs.push_back(mk_req(elc_pkg::OP_LOOKUP, 32'd40, 0, 0, 0));
		pending_reqs.push_back(mk_req(elc_pkg::OP_ADD, 32'd10, 32'd7, 31'd20, 0));
		pending_reqs.push_back(mk_req(elc_pkg::OP_ADD, 32'd10, 32'd7, 31'd2, 0));
		pending_reqs.push_back(mk_req(elc_pkg::OP_LOOKUP, 32'd30, 0, 0, 0));
		pending_reqs.push_back(mk_req(elc_pkg::OP_ADD, 32'h7FFF_FFF0, 32'hFFFF_FFFF,
			31'h7FFF_FFFF, 0));
		pending_reqs.push_back(mk_req(elc_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 0, 0, 0));
		pending_reqs.push_back(mk_req(elc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0));
		pending_reqs.push_back(mk_req(elc_pkg::OP_ADD, 32'd50, 32'd1, 31'd1, 32'd77));
		pending_reqs.push_back(mk_req(elc_pkg::OP_NONE, 32'd10, 32'd1, 31'd1, 0));
		pending_reqs.push_back(mk_req(elc_pkg::OP_LOOKUP, 32'd12, 0, 0, 0));
		pending_reqs.push_back(mk_req(elc_pkg::OP_INVAL, 0, 0, 0, 0));
		pending_reqs.push_back(mk_req(elc_pkg::OP_ADD, 32'd50, 32'd1, 31'd1, 32'd1));
		pending_reqs.push_back(mk_req(elc_pkg::OP_ADD, 32'd50, 32'd1, 31'd1, 32'd2));
		pending_reqs.push_back(mk_req(elc_pkg::OP_LOOKUP, 32'd51, 0, 0, 0));
		for (int i = 0; i < 18; i++)
			pending_reqs.push_back(mk_req(elc_pkg::OP_ADD, 32'd100 + 32'(i) * 10,
				$urandom, 31'd3, 0));
		pending_reqs.push_back(mk_req(elc_pkg::OP_LOOKUP, 32'd101, 0, 0, 0));
		pending_reqs.push_back(mk_req(elc_pkg::OP_LOOKUP, 32'd265, 0, 0, 0));

		// random: mostly clustered adds and lookups near a few bases
		for (int i = 0; i < 8; i++)
			bases[i] = $urandom_range(1, 2000);
		bases[7] = 32'h7FFF_FF00;
		for (int n = 0; n < 1200; n++) begin
			k = $urandom_range(0, 99);
			f = bases[$urandom_range(0, 7)] + $urandom_range(0, 60);
			g = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 32'd0;
			if (k < 3)
				f = $urandom;
			if (k < 2)
				pending_reqs.push_back(mk_req(elc_pkg::OP_INVAL, $urandom, $urandom,
					31'($urandom), $urandom));
			else if (k < 3)
				pending_reqs.push_back(mk_req(elc_pkg::OP_NONE, $urandom, $urandom,
					31'($urandom), $urandom));
			else if (k < 45)
				pending_reqs.push_back(mk_req(elc_pkg::OP_ADD, f, $urandom,
					($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 30)),
					($urandom_range(0, 19) == 0) ? $urandom : g));
			else
				pending_reqs.push_back(mk_req(elc_pkg::OP_LOOKUP, f, $urandom,
					31'($urandom), $urandom));
		end

		wait (pending_reqs.size() == 0);
		@(posedge clk);
		wait (expected_rsps.size() == 0);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#10000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// File: sim.f
design/elc_pkg.sv
design/elc_req_if.sv
design/elc_rsp_if.sv
design/elc_entry_ram.sv
design/extent_lru_cache_core.sv
design/elc_checker.sv
dv/tb_top.sv
